// ===== sv/pfsc_pkg.sv =====
`timescale 1ns / 1ps

package pfsc_pkg;

  // Flow table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W = 32;
  localparam int CNT_W = 32;

  // Count that restarts a flow; a restart leaves START_COUNT + 1 as the expectation
  localparam logic [CNT_W-1:0] START_COUNT = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IN_ORDER      = 3'd0,
    ST_NEW_FLOW      = 3'd1,
    ST_RESTART       = 3'd2,
    ST_MISMATCH      = 3'd3,
    ST_MISMATCH_ZERO = 3'd4,
    ST_FULL          = 3'd5
  } status_t;

  // Table access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [CNT_W-1:0] wr_exp;
  } mem_req_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic              busy;
    logic [FILL_W-1:0] fill_level;
  } ctrl_stat_t;

endpackage

// ===== sv/pfsc_table.sv =====
`timescale 1ns / 1ps

module pfsc_table
  import pfsc_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         mem_req,
  output logic [KEY_W-1:0] rd_key,
  output logic [CNT_W-1:0] rd_exp
);

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0] exp_mem [TABLE_ENTRIES];

  // Write one entry
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      key_mem[mem_req.wr_addr] <= mem_req.wr_key;
      exp_mem[mem_req.wr_addr] <= mem_req.wr_exp;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_key <= key_mem[mem_req.rd_addr];
      rd_exp <= exp_mem[mem_req.rd_addr];
    end
  end

endmodule

// ===== sv/pfsc_ctrl.sv =====
`timescale 1ns / 1ps

module pfsc_ctrl
  import pfsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] flow_id,
  input  logic [CNT_W-1:0] seq_count,
  input  logic             restart_enable,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [CNT_W-1:0] expected_count,
  output mem_req_t         mem_req,
  input  logic [KEY_W-1:0] rd_key,
  input  logic [CNT_W-1:0] rd_exp,
  output ctrl_stat_t       ctrl_stat
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FILL_W-1:0] scan_cnt;
  logic [FILL_W-1:0] fill_level;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              hit_r;
  logic [IDX_W-1:0]  slot_r;
  logic [CNT_W-1:0]  exp_r;

  logic    accept;
  logic    scan_more;
  logic    hit;
  logic    scan_done;
  logic    can_emit;
  logic    table_full;
  status_t status_next;

  assign accept     = in_valid && !in_stall;
  assign scan_more  = (scan_cnt != fill_level);
  assign hit        = pend && (rd_key == key_r);
  assign scan_done  = !scan_more && !pend;
  assign can_emit   = !out_valid || !out_stall;
  assign table_full = (fill_level == FILL_W'(TABLE_ENTRIES));
  assign in_stall   = rst || (state != S_IDLE);

  assign ctrl_stat.busy       = (state != S_IDLE);
  assign ctrl_stat.fill_level = fill_level;

  // Classify the request from the lookup outcome
  always_comb begin
    priority if (!hit_r) begin
      status_next = table_full ? ST_FULL : ST_NEW_FLOW;
    end else if (cnt_r == exp_r) begin
      status_next = ST_IN_ORDER;
    end else if (restart_enable && (cnt_r == START_COUNT)) begin
      status_next = ST_RESTART;
    end else if (cnt_r == '0) begin
      status_next = ST_MISMATCH_ZERO;
    end else begin
      status_next = ST_MISMATCH;
    end
  end

  // Drive table reads during the scan and the single update write
  always_comb begin
    mem_req.rd_en   = (state == S_SCAN) && scan_more;
    mem_req.rd_addr = scan_cnt[IDX_W-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = slot_r;
    mem_req.wr_key  = key_r;
    mem_req.wr_exp  = exp_r + CNT_W'(1);
    if ((state == S_DECIDE) && can_emit) begin
      unique case (status_next)
        ST_NEW_FLOW: begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = fill_level[IDX_W-1:0];
          mem_req.wr_exp  = cnt_r + CNT_W'(1);
        end
        ST_IN_ORDER: begin
          mem_req.wr_en = 1'b1;
        end
        ST_RESTART: begin
          mem_req.wr_en  = 1'b1;
          mem_req.wr_exp = START_COUNT + CNT_W'(1);
        end
        default: begin
          mem_req.wr_en = 1'b0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (hit || scan_done) state_next = S_DECIDE;
      S_DECIDE: if (can_emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_level <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SCAN) && scan_more && !hit;
      if ((state == S_DECIDE) && can_emit && (status_next == ST_NEW_FLOW)) begin
        fill_level <= fill_level + FILL_W'(1);
      end
      if ((state == S_DECIDE) && can_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture request, walk the table, hold the result
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= flow_id;
      cnt_r    <= seq_count;
      scan_cnt <= '0;
    end
    if ((state == S_SCAN) && scan_more) begin
      scan_cnt <= scan_cnt + FILL_W'(1);
      pend_idx <= scan_cnt[IDX_W-1:0];
    end
    if ((state == S_SCAN) && hit) begin
      hit_r  <= 1'b1;
      slot_r <= pend_idx;
      exp_r  <= rd_exp;
    end else if ((state == S_SCAN) && scan_done) begin
      hit_r <= 1'b0;
      exp_r <= '0;
    end
    if ((state == S_DECIDE) && can_emit) begin
      status         <= status_next;
      expected_count <= exp_r;
    end
  end

endmodule

// ===== sv/per_flow_sequence_checker.sv =====
`timescale 1ns / 1ps

// Per-flow sequence checker.
// Input channel (in_valid / in_stall) carries flow_id and seq_count; a
// request is taken at an edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall) returns one status and
// expected_count per request, in request order.
// Configuration: restart_enable is written through cfg_valid / cfg_ready
// (always ready); write it only while the block is idle.
// From accept, the sequencer scans the table from entry 0 up to the first
// hit, or up to fill_level on a miss, one key compare per cycle through
// the single table read port; a decide state then classifies the request
// and makes any table update. in_stall stays high from accept until the
// result is loaded.
// Reset (rst, synchronous) empties the table by zeroing the fill count,
// clears restart_enable and drops any pending result.
// When the receiver stalls, the result waits in the output register; the
// next request is taken and looked up meanwhile, and only its final update
// waits until the output register is free.
module per_flow_sequence_checker
  import pfsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] flow_id,
  input  logic [CNT_W-1:0] seq_count,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [CNT_W-1:0] expected_count,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             restart_enable
);

  logic             restart_en_r;
  mem_req_t         mem_req;
  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] rd_exp;
  ctrl_stat_t       ctrl_stat;

  assign cfg_ready = 1'b1;

  // Hold the restart enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      restart_en_r <= restart_enable;
    end
  end

  pfsc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .flow_id        (flow_id),
    .seq_count      (seq_count),
    .restart_enable (restart_en_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .expected_count (expected_count),
    .mem_req        (mem_req),
    .rd_key         (rd_key),
    .rd_exp         (rd_exp),
    .ctrl_stat      (ctrl_stat)
  );

  pfsc_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_key  (rd_key),
    .rd_exp  (rd_exp)
  );

  // An accepted request keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ctrl_stat.busy)
    else $error("sequencer not busy after accepting a request");

  // Fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl_stat.fill_level <= FILL_W'(TABLE_ENTRIES))
    else $error("fill level beyond table size");

  // Table full is reported only with every entry in use
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (ctrl_stat.fill_level == FILL_W'(TABLE_ENTRIES)))
    else $error("table full reported with free entries");

  // A new flow reports zero expected count
  a_new_flow_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_NEW_FLOW)) |-> (expected_count == '0))
    else $error("new flow with nonzero expected count");

endmodule

// ===== tb/sv/per_flow_sequence_checker_tb.sv =====
`timescale 1ns / 1ps

module per_flow_sequence_checker_tb;
  import pfsc_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } header_t;

  typedef struct packed {
    status_t          st;
    logic [CNT_W-1:0] exp;
  } verdict_t;

  typedef enum int {STALL_NONE, STALL_HOLD, STALL_FLICKER} stall_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] flow_id = '0;
  logic [CNT_W-1:0] seq_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       status;
  logic [CNT_W-1:0] expected_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_restart = 1'b0;

  // Flow table as the checker should see it
  logic             ft_used [TABLE_ENTRIES] = '{default: 1'b0};
  logic [KEY_W-1:0] ft_key  [TABLE_ENTRIES] = '{default: '0};
  logic [CNT_W-1:0] ft_next [TABLE_ENTRIES] = '{default: '0};
  int               ft_fill = 0;
  logic             restart_on = 1'b0;

  // Stimulus planning: flows known so far and their next in-order count
  logic [KEY_W-1:0] plan_key [$];
  logic [CNT_W-1:0] plan_next [$];
  logic             plan_restart = 1'b0;

  header_t  pending_headers [$];
  verdict_t pending_verdicts [$];
  int       planned_total = 0;
  int       results_done = 0;
  int       errors = 0;

  int          drv_burst = 1;
  int          drv_gap = 0;
  header_t     next_hdr;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  verdict_t    want;

  per_flow_sequence_checker dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .flow_id        (flow_id),
    .seq_count      (seq_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .expected_count (expected_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .restart_enable (cfg_restart)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Look up one header, update the flow table and return the expected result
  function automatic verdict_t check_header(header_t h);
    verdict_t v;
    int       slot;
    slot  = -1;
    v.exp = '0;
    for (int i = 0; i < ft_fill; i++) begin
      if (slot < 0 && ft_used[i] && ft_key[i] == h.key) slot = i;
    end
    if (slot < 0) begin
      if (ft_fill < TABLE_ENTRIES) begin
        ft_used[ft_fill] = 1'b1;
        ft_key[ft_fill]  = h.key;
        ft_next[ft_fill] = CNT_W'(h.cnt + 1);
        ft_fill++;
        v.st = ST_NEW_FLOW;
      end else begin
        v.st = ST_FULL;
      end
    end else begin
      v.exp = ft_next[slot];
      if (h.cnt == v.exp) begin
        ft_next[slot] = CNT_W'(v.exp + 1);
        v.st = ST_IN_ORDER;
      end else if (restart_on && h.cnt == START_COUNT) begin
        ft_next[slot] = CNT_W'(START_COUNT + 1);
        v.st = ST_RESTART;
      end else if (h.cnt == '0) begin
        v.st = ST_MISMATCH_ZERO;
      end else begin
        v.st = ST_MISMATCH;
      end
    end
    return v;
  endfunction

  // Queue one request and track the flow's next count for later planning
  task automatic plan_item(input logic [KEY_W-1:0] key, input logic [CNT_W-1:0] cnt);
    int idx;
    idx = -1;
    foreach (plan_key[i]) begin
      if (plan_key[i] == key) idx = i;
    end
    if (idx < 0) begin
      if (plan_key.size() < TABLE_ENTRIES) begin
        plan_key.push_back(key);
        plan_next.push_back(CNT_W'(cnt + 1));
      end
    end else if (cnt == plan_next[idx]) begin
      plan_next[idx] = CNT_W'(cnt + 1);
    end else if (plan_restart && cnt == START_COUNT) begin
      plan_next[idx] = CNT_W'(START_COUNT + 1);
    end
    pending_headers.push_back('{key, cnt});
    planned_total++;
  endtask

  // Mostly in-order traffic on known flows, with new flows, gaps and restarts
  task automatic plan_random(input int n);
    int               r;
    int               pick;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (plan_key.size() == 0 || r < 12) begin
        key = $urandom;
        case ($urandom_range(0, 3))
          0: cnt = $urandom;
          1: cnt = START_COUNT;
          2: cnt = '1 - CNT_W'($urandom_range(0, 3));
          default: cnt = CNT_W'($urandom_range(0, 3));
        endcase
      end else begin
        pick = $urandom_range(0, plan_key.size() - 1);
        key  = plan_key[pick];
        if (r < 75)      cnt = plan_next[pick];
        else if (r < 83) cnt = $urandom;
        else if (r < 88) cnt = '0;
        else if (r < 94) cnt = START_COUNT;
        else if (r < 97) cnt = CNT_W'(plan_next[pick] - 1);
        else             cnt = CNT_W'(plan_next[pick] + 1);
      end
      plan_item(key, cnt);
    end
  endtask

  // Write the restart flag; call right after posedge clk
  task automatic write_restart(input logic v);
    cfg_valid   <= 1'b1;
    cfg_restart <= v;
    do @(posedge clk); while (!cfg_ready);
    restart_on   = v;
    plan_restart = v;
    cfg_valid   <= 1'b0;
  endtask

  // Hold until every planned request has produced its result
  task automatic wait_idle();
    do @(posedge clk); while (results_done < planned_total);
    repeat (4) @(posedge clk);
  endtask

  // Driver: present requests in bursts, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_verdicts.push_back(check_header('{flow_id, seq_count}));
      if (!in_valid || !in_stall) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_headers.size() > 0) begin
          next_hdr = pending_headers.pop_front();
          in_valid  <= 1'b1;
          flow_id   <= next_hdr.key;
          seq_count <= next_hdr.cnt;
          drv_burst--;
          if (drv_burst <= 0) begin
            drv_burst = $urandom_range(1, 12);
            case ($urandom_range(0, 2))
              0: drv_gap = 0;
              1: drv_gap = $urandom_range(1, 10);
              default: drv_gap = $urandom_range(1, 80);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, drive stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_done++;
        if (pending_verdicts.size() == 0) begin
          $error("result with no request pending: status %0d expected_count %0h",
                 status, expected_count);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            errors++;
          end
          if (expected_count !== want.exp) begin
            $error("expected_count: expected %0h, actual %0h", want.exp, expected_count);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(1, 60);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_HOLD: out_stall <= 1'b1;
        default:    out_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, wrap, mismatch kinds with restart off
    write_restart(1'b0);
    plan_item('0, '0);
    plan_item('1, '1);
    plan_item('1, '0);
    plan_item('0, START_COUNT);
    plan_item('0, 32'd5);
    plan_item('0, '0);
    plan_item('0, START_COUNT);
    plan_item(32'h1234_5678, 32'h8000_0000);
    plan_item(32'h1234_5678, 32'h8000_0001);
    plan_item(32'hA5A5_A5A5, START_COUNT);
    wait_idle();

    // Directed: restart, match taking priority over restart
    write_restart(1'b1);
    plan_item('0, START_COUNT);
    plan_item('0, 32'd2);
    plan_item('1, START_COUNT);
    plan_item('1, '0);
    plan_item('1, '1);
    plan_item(32'h1234_5678, START_COUNT);
    plan_item(32'h1234_5678, '0);
    wait_idle();

    // Random phases, alternating the restart flag; the table fills midway
    for (int ph = 0; ph < 4; ph++) begin
      write_restart(ph[0]);
      plan_random(225);
      wait_idle();
    end

    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
